// File: rtl/core/gradient_cube_face_code_unit_assert.svh
// Assertion macros for the cube face code unit.
// Included by the top level; needs clk and rst in scope of each use.
`ifndef GRADIENT_CUBE_FACE_CODE_UNIT_ASSERT_SVH
`define GRADIENT_CUBE_FACE_CODE_UNIT_ASSERT_SVH

// same-cycle implication
`define GCFC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gcfc assertion failed");

// next-cycle implication
`define GCFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gcfc assertion failed");

`endif

// File: rtl/core/gcfc_pkg.sv
// Package of the cube face code unit: widths, face codes, stage buses.
// Holds the shared divide step; no dependencies.
package gcfc_pkg;

  localparam int COMPONENT_BITS = 6;
  localparam int INPUT_WIDTH    = 16;

  localparam int G_NORM   = 1 << (COMPONENT_BITS - 1);
  localparam int MAG_W    = INPUT_WIDTH;
  localparam int DIFF_W   = INPUT_WIDTH + 1;
  localparam int REM_W    = INPUT_WIDTH - 1;
  localparam int QUO_W    = COMPONENT_BITS + 1;
  localparam int FACE_W   = 3;
  localparam int CODE_W   = FACE_W + 2 * COMPONENT_BITS;
  localparam int PACKED_W = 15;

  localparam int IN_TDATA_W  = ((3 * INPUT_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((PACKED_W + FACE_W + 7) / 8) * 8;

  typedef logic signed [INPUT_WIDTH-1:0] grad_t;
  typedef logic [MAG_W-1:0]              mag_t;
  typedef logic [FACE_W-1:0]             face_t;
  typedef logic [COMPONENT_BITS-1:0]     comp_t;

  localparam face_t FACE_NEG_X = 3'd0;
  localparam face_t FACE_NEG_Y = 3'd1;
  localparam face_t FACE_NEG_Z = 3'd2;
  localparam face_t FACE_POS_X = 3'd3;
  localparam face_t FACE_POS_Y = 3'd4;
  localparam face_t FACE_POS_Z = 3'd5;
  localparam face_t FACE_ZERO  = 3'd6;

  localparam comp_t COMP_MAX = comp_t'(2 * G_NORM - 1);

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] feed;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    face_t     face;
    mag_t      mag;
    div_lane_t first;
    div_lane_t second;
  } div_bus_t;

  function automatic div_lane_t div_lane_step(input div_lane_t lane, input mag_t mag);
    logic [MAG_W-1:0] shifted;
    logic             ge;
    logic [MAG_W-1:0] diff;
    div_lane_t        res;
    shifted  = {lane.rem, lane.feed[QUO_W-1]};
    ge       = (shifted >= mag);
    diff     = ge ? (shifted - mag) : shifted;
    res.rem  = diff[REM_W-1:0];
    res.feed = {lane.feed[QUO_W-2:0], 1'b0};
    res.quo  = {lane.quo[QUO_W-2:0], ge};
    return res;
  endfunction

endpackage

// File: rtl/core/gradient_cube_face_code_unit.sv
// Top level of the cube face code unit: front end, divide pipeline, pack.
// Depends on gcfc_pkg, gcfc_front, gcfc_div_step, gcfc_pack and the assert header.
//
//   channel   dir  beat contents (low bit up)
//   s_axis    in   tdata: grad_x[15:0], grad_y[31:16], grad_z[47:32]
//   m_axis    out  tdata: packed_code[14:0], face_index[17:15], zero pad
//
// One beat enters per cycle while m_axis is not stalled; the stages are:
// three front stages, one divide stage per quotient bit, one output stage.
// The divide pipeline retires one quotient bit per lane per stage.
// Synchronous reset clears the valid bits; payload registers are not reset.
// A stall on m_axis freezes every stage together, and s_axis_tready drops.
`include "gradient_cube_face_code_unit_assert.svh"

module gradient_cube_face_code_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [gcfc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // grad_x, grad_y, grad_z
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [gcfc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata   // packed_code, face_index
);
  import gcfc_pkg::*;

  logic     advance;
  logic     div_valid [QUO_W+1];
  div_bus_t div_bus   [QUO_W+1];

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  gcfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (s_axis_tvalid),
    .in_data   (s_axis_tdata),
    .out_valid (div_valid[0]),
    .out_bus   (div_bus[0])
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    gcfc_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .in_valid  (div_valid[k]),
      .in_bus    (div_bus[k]),
      .out_valid (div_valid[k+1]),
      .out_bus   (div_bus[k+1])
    );
  end

  gcfc_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (div_valid[QUO_W]),
    .in_bus    (div_bus[QUO_W]),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata)
  );

  `GCFC_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, u_front.v1)
  `GCFC_ASSERT_IMP(a_rise_from_div, $rose(m_axis_tvalid), $past(div_valid[QUO_W]))
  `GCFC_ASSERT_IMP(a_face_in_code, m_axis_tvalid,
    m_axis_tdata[PACKED_W-1:2*COMPONENT_BITS] == m_axis_tdata[PACKED_W +: FACE_W])
  `GCFC_ASSERT_IMP(a_zero_face_blank,
    m_axis_tvalid && (m_axis_tdata[PACKED_W +: FACE_W] == FACE_ZERO),
    m_axis_tdata[2*COMPONENT_BITS-1:0] == '0)

endmodule

// File: rtl/core/gcfc_front.sv
// Front end: magnitudes, dominant axis and face, divide operand setup.
// Three register stages; depends on gcfc_pkg.
module gcfc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic                       in_valid,
  input  logic [gcfc_pkg::IN_TDATA_W-1:0] in_data,
  output logic                       out_valid,
  output gcfc_pkg::div_bus_t         out_bus
);
  import gcfc_pkg::*;

  grad_t g1 [3];
  mag_t  m1 [3];
  logic  v1;

  face_t face2;
  mag_t  mag2;
  grad_t ga2;
  grad_t gb2;
  logic  v2;

  face_t face_next;
  mag_t  mag_next;
  grad_t ga_next;
  grad_t gb_next;
  logic [1:0] axis;

  logic signed [DIFF_W:0] da;
  logic signed [DIFF_W:0] db;
  logic [DIFF_W-1:0] ua;
  logic [DIFF_W-1:0] ub;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        g1[i] <= grad_t'(in_data[i*INPUT_WIDTH +: INPUT_WIDTH]);
        m1[i] <= in_data[i*INPUT_WIDTH + INPUT_WIDTH - 1]
                 ? mag_t'(-in_data[i*INPUT_WIDTH +: INPUT_WIDTH])
                 : mag_t'(in_data[i*INPUT_WIDTH +: INPUT_WIDTH]);
      end
    end
  end

  always_comb begin
    face_next = FACE_ZERO;
    mag_next  = '0;
    axis      = 2'd0;
    if (m1[0] > mag_next) begin
      face_next = g1[0][INPUT_WIDTH-1] ? FACE_NEG_X : FACE_POS_X;
      mag_next  = m1[0];
      axis      = 2'd0;
    end
    if (m1[1] > mag_next) begin
      face_next = g1[1][INPUT_WIDTH-1] ? FACE_NEG_Y : FACE_POS_Y;
      mag_next  = m1[1];
      axis      = 2'd1;
    end
    if (m1[2] > mag_next) begin
      face_next = g1[2][INPUT_WIDTH-1] ? FACE_NEG_Z : FACE_POS_Z;
      mag_next  = m1[2];
      axis      = 2'd2;
    end
    ga_next = (axis == 2'd0) ? g1[1] : g1[0];
    gb_next = (axis == 2'd2) ? g1[1] : g1[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      face2 <= face_next;
      mag2  <= mag_next;
      ga2   <= ga_next;
      gb2   <= gb_next;
    end
  end

  assign da = $signed({2'b00, mag2}) - (DIFF_W + 1)'(ga2);
  assign db = $signed({2'b00, mag2}) - (DIFF_W + 1)'(gb2);
  assign ua = da[DIFF_W-1:0];
  assign ub = db[DIFF_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_bus.face        <= face2;
      out_bus.mag         <= mag2;
      out_bus.first.rem   <= ua[DIFF_W-1:2];
      out_bus.first.feed  <= {ua[1:0], {(COMPONENT_BITS-1){1'b0}}};
      out_bus.first.quo   <= '0;
      out_bus.second.rem  <= ub[DIFF_W-1:2];
      out_bus.second.feed <= {ub[1:0], {(COMPONENT_BITS-1){1'b0}}};
      out_bus.second.quo  <= '0;
    end
  end

endmodule

// File: rtl/core/gcfc_div_step.sv
// One registered restoring-divide step for both tangential lanes.
// Depends on gcfc_pkg.
module gcfc_div_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  gcfc_pkg::div_bus_t in_bus,
  output logic               out_valid,
  output gcfc_pkg::div_bus_t out_bus
);
  import gcfc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_bus.face   <= in_bus.face;
      out_bus.mag    <= in_bus.mag;
      out_bus.first  <= div_lane_step(in_bus.first, in_bus.mag);
      out_bus.second <= div_lane_step(in_bus.second, in_bus.mag);
    end
  end

endmodule

// File: rtl/core/gcfc_pack.sv
// Output stage: clamp quotients, pack the code, hold the result beat.
// Depends on gcfc_pkg.
module gcfc_pack (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             advance,
  input  logic                             in_valid,
  input  gcfc_pkg::div_bus_t               in_bus,
  output logic                             out_valid,
  output logic [gcfc_pkg::OUT_TDATA_W-1:0] out_data
);
  import gcfc_pkg::*;

  comp_t              t1;
  comp_t              t2;
  logic [CODE_W-1:0]  code;
  logic [PACKED_W-1:0] packed_code;

  always_comb begin
    t1 = in_bus.first.quo[QUO_W-1] ? COMP_MAX : in_bus.first.quo[COMPONENT_BITS-1:0];
    t2 = in_bus.second.quo[QUO_W-1] ? COMP_MAX : in_bus.second.quo[COMPONENT_BITS-1:0];
    if (in_bus.face == FACE_ZERO) begin
      t1 = '0;
      t2 = '0;
    end
    code        = {in_bus.face, t1, t2};
    packed_code = PACKED_W'(code);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= OUT_TDATA_W'({in_bus.face, packed_code});
    end
  end

endmodule

// File: sim/gcfc_face_code_checker.sv
// Checker for the cube face code unit: watches both stream channels, computes
// the expected face and packed code of each accepted gradient, and compares.
// Depends on gcfc_pkg for widths and face codes.
module gcfc_face_code_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [gcfc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [gcfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int unsigned                      errors,
  output int unsigned                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import gcfc_pkg::*;

  typedef struct packed {
    face_t                face;
    logic [PACKED_W-1:0]  code;
  } face_code_t;

  localparam face_t NEG_FACE [3] = '{FACE_NEG_X, FACE_NEG_Y, FACE_NEG_Z};
  localparam face_t POS_FACE [3] = '{FACE_POS_X, FACE_POS_Y, FACE_POS_Z};

  face_code_t expected_codes[$];
  int unsigned n_beats_out = 0;

  initial begin
    errors  = 0;
    pending = 0;
  end

  function automatic comp_t quantize_tangent(input longint g, input longint m);
    longint t;
    t = ((m - g) * G_NORM) / m;
    if (t > COMP_MAX) t = COMP_MAX;
    return comp_t'(t);
  endfunction

  function automatic face_code_t encode_gradient(input logic [IN_TDATA_W-1:0] beat);
    longint     g [3];
    longint     m;
    int         axis;
    int         ia;
    int         ib;
    face_t      face;
    comp_t      t1;
    comp_t      t2;
    face_code_t res;
    m    = 0;
    axis = 0;
    face = FACE_ZERO;
    for (int i = 0; i < 3; i++) begin
      g[i] = longint'(grad_t'(beat[i*INPUT_WIDTH +: INPUT_WIDTH]));
    end
    for (int i = 0; i < 3; i++) begin
      if (g[i] < -m) begin
        face = NEG_FACE[i];
        axis = i;
        m    = -g[i];
      end else if (g[i] > m) begin
        face = POS_FACE[i];
        axis = i;
        m    = g[i];
      end
    end
    if (face == FACE_ZERO) begin
      t1 = '0;
      t2 = '0;
    end else begin
      ia = (axis == 0) ? 1 : 0;
      ib = (axis == 2) ? 1 : 2;
      t1 = quantize_tangent(g[ia], m);
      t2 = quantize_tangent(g[ib], m);
    end
    res.face = face;
    res.code = PACKED_W'({face, t1, t2});
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] beat %0d: %s mismatch, got 0x%0h, want 0x%0h",
             $realtime, n_beats_out, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    face_code_t want;
    logic [PACKED_W-1:0] got_code;
    face_t got_face;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) expected_codes.push_back(encode_gradient(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got_code = m_axis_tdata[PACKED_W-1:0];
        got_face = m_axis_tdata[PACKED_W +: FACE_W];
        if (expected_codes.size() == 0) begin
          report_mismatch("unexpected beat", 32'(m_axis_tdata), 32'd0);
        end else begin
          want = expected_codes.pop_front();
          if (got_code !== want.code) report_mismatch("packed_code", got_code, want.code);
          if (got_face !== want.face) report_mismatch("face_index", got_face, want.face);
        end
        n_beats_out++;
      end
      pending = expected_codes.size();
    end
  end

endmodule

// File: sim/tb_gradient_cube_face_code_unit.sv
// Testbench top for the cube face code unit: clock, reset, gradient stimulus
// with random idling on both channels, and the final verdict.
// Depends on gcfc_pkg, gradient_cube_face_code_unit and gcfc_face_code_checker.
module tb_gradient_cube_face_code_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gcfc_pkg::*;

  localparam int N_RANDOM     = 1800;
  localparam int STEADY_FIRST = 700;
  localparam int STEADY_LAST  = 1000;
  localparam int DRAIN_CYCLES = 3 * (COMPONENT_BITS + 5);

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   steady        = 1'b0;
  int unsigned            errors;
  int unsigned            pending;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  gradient_cube_face_code_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gcfc_face_code_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .errors        (errors),
    .pending       (pending)
  );

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 33);
  end

  task automatic send_gradient(input grad_t gx, input grad_t gy, input grad_t gz);
    if (!steady && $urandom_range(99) < 33) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({gz, gy, gx});
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic grad_t random_component(input int unsigned mode, input grad_t mag);
    grad_t v;
    case (mode)
      0: v = grad_t'($urandom());
      1: v = grad_t'(int'($urandom_range(8)) - 4);
      2: v = $urandom_range(1) ? mag : -mag;
      default: begin
        case ($urandom_range(5))
          0: v = grad_t'(16'h8000);
          1: v = grad_t'(16'h7fff);
          2: v = '0;
          3: v = '1;
          4: v = grad_t'(1);
          default: v = grad_t'($urandom());
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin
    int unsigned sel;
    int unsigned mode;
    grad_t       mag;
    grad_t       g [3];
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_gradient(0, 0, 0);
    send_gradient(32767, 0, 0);
    send_gradient(-32768, 0, 0);
    send_gradient(0, 32767, 0);
    send_gradient(0, -32768, 0);
    send_gradient(0, 0, 32767);
    send_gradient(0, 0, -32768);
    send_gradient(-32768, -32768, -32768);
    send_gradient(32767, 32767, 32767);
    send_gradient(-32768, 32767, -32767);
    send_gradient(-32767, 32767, 0);
    send_gradient(5, 5, 5);
    send_gradient(5, -5, 0);
    send_gradient(-7, 7, -7);
    send_gradient(0, -9, 9);
    send_gradient(1, -1, 1);
    send_gradient(-1, 0, 0);
    send_gradient(0, 0, 1);
    send_gradient(0, -1, 0);
    send_gradient(3, 2, -1);
    send_gradient(100, -33, 67);
    send_gradient(12, -40, 39);
    send_gradient(0, 1, -1);

    for (int n = 0; n < N_RANDOM; n++) begin
      steady <= (n >= STEADY_FIRST) && (n < STEADY_LAST);
      sel  = $urandom_range(99);
      mode = (sel < 45) ? 0 : (sel < 65) ? 1 : (sel < 85) ? 2 : 3;
      mag  = grad_t'($urandom_range(32767));
      for (int i = 0; i < 3; i++) g[i] = random_component(mode, mag);
      if (mode == 2) g[$urandom_range(2)] = grad_t'($urandom());
      send_gradient(g[0], g[1], g[2]);
    end
    s_axis_tvalid <= 1'b0;
    steady        <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
